>>> rtl/core/sorted_table_binary_search_defines.svh
// Assertion macros shared by the checker of the sorted-table search block.
// Every macro expects signals named clk and rst_n in the scope of its use.
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define STS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sts_pkg.sv
// Shared types and constants of the sorted-table search block.
// No dependencies; compiled first.
package sts_pkg;

    localparam int IDX_W          = 4;   // index and range register width
    localparam int IDX_LIMIT      = 16;  // slots an index can name
    localparam int POS_W          = 5;   // one-based position
    localparam int PROBE_W        = 3;   // probe count
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    // Register indexes, taken from paddr[2]
    localparam logic REG_FIRST_INDEX = 1'b0;
    localparam logic REG_LAST_INDEX  = 1'b1;

    localparam logic [IDX_W-1:0] FIRST_INDEX_RESET = 4'd0;
    localparam logic [IDX_W-1:0] LAST_INDEX_RESET  = 4'd15;

    // Request opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] last_index;
    } cfg_t;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic [PROBE_W-1:0] probes;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

>>> rtl/core/sts_if.sv
// Request and result channel interfaces of the sorted-table search block.
// Depends on sts_pkg.
interface sts_req_if #(
    parameter int DATA_WIDTH = sts_pkg::DATA_WIDTH_DEF
);
    import sts_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [IDX_W-1:0]             index;
    logic signed [DATA_WIDTH-1:0] value;

    modport source (output valid, op, index, value, input ready);
    modport sink   (input valid, op, index, value, output ready);
endinterface

interface sts_rsp_if;
    import sts_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [POS_W-1:0]   position;
    logic [PROBE_W-1:0] probes;

    modport source (output valid, found, position, probes, input ready);
    modport sink   (input valid, found, position, probes, output ready);
endinterface

>>> rtl/core/sorted_table_binary_search.sv
// Sorted-table binary search, top level. Uses sts_pkg, sts_if, sts_cfg, sts_engine.
// Write request: taken while idle, stored in the table, no result.
// Search request: P probes, each a RAM read, then a compare; rsp.valid rises when
// the result register loads in ST_DONE, P <= 5 for a 16-slot range.
// One request in flight; the RAM read-compare loop and a held result (rsp.ready low) set the rate.
// Async reset clears FSM and result valid, sets range registers to 0 and 15; table is undefined until written.
module sorted_table_binary_search #(
    parameter int DEPTH      = sts_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = sts_pkg::DATA_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // APB configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sts_pkg::APB_AW-1:0] paddr,
    input  logic [sts_pkg::APB_DW-1:0] pwdata,
    output logic [sts_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    // Request and result channels
    sts_req_if.sink                    req,
    sts_rsp_if.source                  rsp
);
    import sts_pkg::*;

    cfg_t    cfg;
    result_t result;

    // Range bounds: first_index at 0x0, last_index at 0x4.
    sts_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The engine owns the table RAM. A request is taken only while the
    // engine is idle; a finished result sits in its output register, so a
    // new request can be taken while the result waits for rsp.ready.
    sts_engine #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req_valid  (req.valid),
        .req_ready  (req.ready),
        .req_op     (req.op),
        .req_index  (req.index),
        .req_value  (req.value),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .rsp_result (result)
    );

    // Result payload fans out to the channel fields.
    assign rsp.found    = result.found;
    assign rsp.position = result.position;
    assign rsp.probes   = result.probes;
endmodule

>>> rtl/core/sts_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/core/sts_cfg.sv
// APB register file: search range bounds.
// Depends on sts_pkg.
module sts_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [sts_pkg::APB_AW-1:0] paddr,
    input  logic [sts_pkg::APB_DW-1:0] pwdata,
    output logic [sts_pkg::APB_DW-1:0] prdata,
    output logic                      pready,
    output sts_pkg::cfg_t             cfg
);
    import sts_pkg::*;

    logic [IDX_W-1:0] first_index_reg, first_index_next;
    logic [IDX_W-1:0] last_index_reg,  last_index_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        first_index_next = first_index_reg;
        last_index_next  = last_index_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_FIRST_INDEX: first_index_next = pwdata[IDX_W-1:0];
                REG_LAST_INDEX:  last_index_next  = pwdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FIRST_INDEX: prdata = {{(APB_DW-IDX_W){1'b0}}, first_index_reg};
            REG_LAST_INDEX:  prdata = {{(APB_DW-IDX_W){1'b0}}, last_index_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_index_reg <= FIRST_INDEX_RESET;
            last_index_reg  <= LAST_INDEX_RESET;
        end
        else
        begin
            first_index_reg <= first_index_next;
            last_index_reg  <= last_index_next;
        end
    end

    assign cfg.first_index = first_index_reg;
    assign cfg.last_index  = last_index_reg;
endmodule

>>> rtl/core/sts_engine.sv
// Search sequencer: table RAM, probe loop and result register.
// Depends on sts_pkg and sts_ram.
module sts_engine #(
    parameter int DEPTH      = sts_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = sts_pkg::DATA_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sts_pkg::cfg_t                  cfg,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic                           req_op,
    input  logic [sts_pkg::IDX_W-1:0]      req_index,
    input  logic signed [DATA_WIDTH-1:0]   req_value,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output sts_pkg::result_t               rsp_result
);
    import sts_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DCAP = (DEPTH > IDX_LIMIT) ? IDX_LIMIT : DEPTH;
    localparam logic [IDX_W:0] DEPTH_CAP = (IDX_W+1)'(DCAP);

    state_t state_reg, state_next;

    // Range kept as [lo, hi_p1): hi_p1 is one past the last live index.
    logic [IDX_W:0]               lo_reg,   lo_next;
    logic [IDX_W:0]               hip1_reg, hip1_next;
    logic [IDX_W-1:0]             mid_reg,  mid_next;
    logic signed [DATA_WIDTH-1:0] key_reg,  key_next;
    logic [PROBE_W-1:0]           miss_reg, miss_next;
    logic                         hit_reg,  hit_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    result_t                      res_reg,  res_next;

    logic                         accept, accept_search;
    logic                         probe_en, cmp_en, load_out;
    logic                         range_open, entry_eq, key_gt;
    logic [IDX_W+1:0]             mid_sum;
    logic [IDX_W-1:0]             mid_calc;
    logic [IDX_W:0]               last_p1, start_hip1;
    logic                         ram_we;
    logic [IDX_W+AW-1:0]          waddr_wide, raddr_wide;
    logic [AW-1:0]                ram_waddr, ram_raddr;
    logic signed [DATA_WIDTH-1:0] ram_rdata;

    sts_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // FSM outputs
    always_comb
    begin
        req_ready = 1'b0;
        probe_en  = 1'b0;
        cmp_en    = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  req_ready = 1'b1;
            ST_PROBE: probe_en  = 1'b1;
            ST_CMP:   cmp_en    = 1'b1;
            ST_DONE:  load_out  = !rsp_valid_reg || rsp_ready;
            default: ;
        endcase
    end

    assign accept        = req_valid && req_ready;
    assign accept_search = accept && (req_op == OP_SEARCH);
    assign ram_we        = accept && (req_op == OP_WRITE) && ({1'b0, req_index} < DEPTH_CAP);

    assign waddr_wide = {{AW{1'b0}}, req_index};
    assign raddr_wide = {{AW{1'b0}}, mid_calc};
    assign ram_waddr  = waddr_wide[AW-1:0];
    assign ram_raddr  = raddr_wide[AW-1:0];

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hip1_reg} - (IDX_W+2)'(1);
    assign mid_calc = mid_sum[IDX_W:1];

    // last_index saturates at the table end
    assign last_p1    = {1'b0, cfg.last_index} + (IDX_W+1)'(1);
    assign start_hip1 = (last_p1 > DEPTH_CAP) ? DEPTH_CAP : last_p1;

    assign entry_eq = (ram_rdata == key_reg);
    assign key_gt   = (key_reg > ram_rdata);

    always_comb
    begin
        lo_next   = lo_reg;
        hip1_next = hip1_reg;
        key_next  = key_reg;
        miss_next = miss_reg;
        hit_next  = hit_reg;
        mid_next  = mid_reg;
        if (accept_search)
        begin
            lo_next   = {1'b0, cfg.first_index};
            hip1_next = start_hip1;
            key_next  = req_value;
            miss_next = '0;
            hit_next  = 1'b0;
        end
        if (probe_en)
        begin
            mid_next = mid_calc;
        end
        if (cmp_en)
        begin
            if (entry_eq)
            begin
                hit_next = 1'b1;
            end
            else
            begin
                miss_next = miss_reg + PROBE_W'(1);
                if (key_gt)
                begin
                    lo_next = {1'b0, mid_reg} + (IDX_W+1)'(1);
                end
                else
                begin
                    hip1_next = {1'b0, mid_reg};
                end
            end
        end
        range_open = (lo_next < hip1_next);
    end

    // FSM next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_search)
                begin
                    state_next = range_open ? ST_PROBE : ST_DONE;
                end
            end
            ST_PROBE: state_next = ST_CMP;
            ST_CMP:   state_next = (entry_eq || !range_open) ? ST_DONE : ST_PROBE;
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Result register
    always_comb
    begin
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (load_out)
        begin
            rsp_valid_next    = 1'b1;
            res_next.found    = hit_reg;
            res_next.position = hit_reg ? (POS_W'(mid_reg) + POS_W'(1)) : '0;
            res_next.probes   = miss_reg + PROBE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hip1_reg <= hip1_next;
        mid_reg  <= mid_next;
        key_reg  <= key_next;
        miss_reg <= miss_next;
        hit_reg  <= hit_next;
        res_reg  <= res_next;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign rsp_result = res_reg;
endmodule

>>> rtl/core/sts_checker.sv
// Port-level checker for the sorted-table search block, plus its bind.
// Depends on sts_pkg and sorted_table_binary_search_defines.svh.
`include "sorted_table_binary_search_defines.svh"

module sts_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        req_op,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_found,
    input logic [sts_pkg::POS_W-1:0]   rsp_position,
    input logic [sts_pkg::PROBE_W-1:0] rsp_probes
);
    import sts_pkg::*;

    `STS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped before taken")

    `STS_ASSERT_NOW(a_pos_found, rsp_valid, rsp_found == (rsp_position != '0), "position disagrees with found")

    `STS_ASSERT_NOW(a_probe_range, rsp_valid, (rsp_probes != '0) && (rsp_probes <= PROBE_W'(6)), "probe count out of range")

    `STS_ASSERT_NEXT(a_write_silent, req_valid && req_ready && (req_op == OP_WRITE) && !rsp_valid, !rsp_valid, "write request produced a result")
endmodule

bind sorted_table_binary_search sts_checker u_sts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_op       (req.op),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_found    (rsp.found),
    .rsp_position (rsp.position),
    .rsp_probes   (rsp.probes)
);

>>> tb/tb_sorted_table_binary_search.sv
// Testbench for sorted_table_binary_search: directed and random table writes, searches
// and range settings, checked against a built-in binary search predictor.
// Depends on sts_pkg, sts_req_if / sts_rsp_if and the RTL of the block.
module tb_sorted_table_binary_search;
    import sts_pkg::*;

    localparam int TABLE_DEPTH   = DEPTH_DEF;
    localparam int SETTLE_CYCLES = 16;    // wait after the last owed result
    localparam int STALL_LIMIT   = 5000;  // cycles with no handshake at all
    localparam int RANDOM_ITEMS  = 1950;

    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    sts_req_if #(.DATA_WIDTH(DATA_WIDTH_DEF)) req_ch ();
    sts_rsp_if rsp_ch ();

    sorted_table_binary_search #(
        .DEPTH      (TABLE_DEPTH),
        .DATA_WIDTH (DATA_WIDTH_DEF)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch.sink),
        .rsp     (rsp_ch.source)
    );

    // Mirror of the block's state: table contents and search range
    logic signed [31:0] slot_words [TABLE_DEPTH];
    logic [IDX_W-1:0]   range_first;
    logic [IDX_W-1:0]   range_last;

    // Search results still owed by the block, oldest first
    result_t pending_results [$];

    int unsigned src_idle_pct;
    int unsigned rcv_idle_pct;
    int unsigned requests_sent;
    int unsigned writes_sent;
    int unsigned searches_sent;
    int unsigned hits_predicted;
    int unsigned empty_ranges;
    int unsigned range_settings;
    int unsigned results_checked;
    int unsigned mismatches;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Binary search over the configured range, exactly as the block walks it.
    function automatic result_t search_outcome(input logic signed [31:0] key);
        int      lo;
        int      hi;
        int      mid;
        int      misses;
        result_t outcome;
        begin
            outcome = '0;
            misses  = 0;
            lo      = int'(range_first);
            hi      = int'(range_last);
            if (hi > TABLE_DEPTH - 1)
                hi = TABLE_DEPTH - 1;
            while (lo <= hi && !outcome.found)
            begin
                mid = (lo + hi) / 2;
                if (slot_words[IDX_W'(mid)] == key)
                begin
                    outcome.found    = 1'b1;
                    outcome.position = POS_W'(mid + 1);
                end
                else
                begin
                    misses++;
                    if (key > slot_words[IDX_W'(mid)])
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
            end
            outcome.probes = PROBE_W'(misses + 1);
            return outcome;
        end
    endfunction

    // Offer one request; the mirror and the expected results are updated at the
    // edge where the block takes it. valid stays high on return so that a
    // following request can go out back to back.
    task automatic send_request(input logic op, input logic [IDX_W-1:0] slot,
                                input logic signed [31:0] data);
        result_t outcome;
        begin
            @(negedge clk);
            while ($urandom_range(99) < src_idle_pct)
            begin
                req_ch.valid <= 1'b0;
                @(negedge clk);
            end
            req_ch.valid <= 1'b1;
            req_ch.op    <= op;
            req_ch.index <= slot;
            req_ch.value <= data;
            do
                @(posedge clk);
            while (!(req_ch.valid && req_ch.ready));
            requests_sent++;
            if (op == OP_WRITE)
            begin
                slot_words[slot] = data;
                writes_sent++;
            end
            else
            begin
                outcome = search_outcome(data);
                pending_results.push_back(outcome);
                searches_sent++;
                if (outcome.found)
                    hits_predicted++;
                if (range_first > range_last)
                    empty_ranges++;
            end
        end
    endtask

    // Drop valid, wait for every owed result, then let a trailing write settle.
    task automatic drain_results();
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // APB write: setup cycle, then access; upper data bits carry junk on purpose.
    task automatic apb_write(input logic reg_sel, input logic [IDX_W-1:0] field);
        logic [APB_DW-1:0] word;
        begin
            word = $urandom;
            word[IDX_W-1:0] = field;
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {reg_sel, 2'b00};
            pwdata  <= word;
            @(negedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            if (reg_sel == REG_FIRST_INDEX)
                range_first = field;
            else
                range_last = field;
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // Range registers only change with the block idle.
    task automatic set_search_range(input logic [IDX_W-1:0] first,
                                    input logic [IDX_W-1:0] last);
        begin
            drain_results();
            apb_write(REG_FIRST_INDEX, first);
            apb_write(REG_LAST_INDEX, last);
            range_settings++;
        end
    endtask

    // Fill every slot (nothing is ever read unwritten), extremes at both ends,
    // then hit min, max, the first midpoint and a missing key.
    task automatic test_table_extremes();
        int s;
        begin
            for (s = 0; s < TABLE_DEPTH; s++)
            begin
                if (s == 0)
                    send_request(OP_WRITE, IDX_W'(s), WORD_MIN);
                else if (s == TABLE_DEPTH - 1)
                    send_request(OP_WRITE, IDX_W'(s), WORD_MAX);
                else
                    send_request(OP_WRITE, IDX_W'(s), (s - 8) * 32'sd123457);
            end
            send_request(OP_SEARCH, 4'hf, WORD_MIN);
            send_request(OP_SEARCH, 4'h0, WORD_MAX);
            send_request(OP_SEARCH, 4'h5, slot_words[4'd7]);
            send_request(OP_SEARCH, 4'ha, WORD_MIN + 1);
        end
    endtask

    // Single-slot range at the top, empty range, one-slot range at the
    // bottom, then back to the full table.
    task automatic test_range_limits();
        begin
            set_search_range(4'd15, 4'd15);
            send_request(OP_SEARCH, 4'h3, WORD_MAX);
            send_request(OP_SEARCH, 4'h3, slot_words[4'd0]);
            set_search_range(4'd9, 4'd2);
            send_request(OP_SEARCH, 4'h7, slot_words[4'd5]);
            set_search_range(4'd0, 4'd0);
            send_request(OP_SEARCH, 4'hc, WORD_MIN);
            set_search_range(FIRST_INDEX_RESET, LAST_INDEX_RESET);
            send_request(OP_SEARCH, 4'h1, slot_words[4'd12]);
        end
    endtask

    // An entry out of order: the halving walk still decides what is found.
    task automatic test_unsorted_entry();
        begin
            send_request(OP_WRITE, 4'd3, WORD_MAX);
            send_request(OP_SEARCH, 4'h9, WORD_MAX);
            send_request(OP_SEARCH, 4'h2, slot_words[4'd2]);
        end
    endtask

    // Random rounds: mostly a fresh sorted table followed by a burst of
    // searches, sometimes a few stray unsorted writes instead. Range changes
    // between rounds also give the full-drain pause.
    task automatic run_random_phase(input int unsigned src_pct, input int unsigned rcv_pct,
                                    input int unsigned goal);
        int          s;
        int          n;
        int unsigned pick;
        int unsigned step_cap;
        longint      running;
        longint      span;
        logic signed [31:0] key;
        logic [IDX_W-1:0]   lo_pick;
        logic [IDX_W-1:0]   hi_pick;
        bit          first_round;
        begin
            src_idle_pct = src_pct;
            rcv_idle_pct = rcv_pct;
            first_round  = 1'b1;
            while (requests_sent < goal)
            begin
                if (first_round || $urandom_range(2) == 0)
                begin
                    pick = $urandom_range(9);
                    if (pick < 5)
                    begin
                        lo_pick = 4'd0;
                        hi_pick = 4'd15;
                    end
                    else if (pick == 5)
                    begin
                        lo_pick = 4'd15;
                        hi_pick = 4'd15;
                    end
                    else if (pick == 6)
                    begin
                        lo_pick = 4'd0;
                        hi_pick = 4'd0;
                    end
                    else if (pick == 7)
                    begin
                        lo_pick = 4'd15;
                        hi_pick = 4'd0;
                    end
                    else
                    begin
                        lo_pick = IDX_W'($urandom);
                        hi_pick = IDX_W'($urandom);
                    end
                    set_search_range(lo_pick, hi_pick);
                    first_round = 1'b0;
                end

                if ($urandom_range(99) < 15)
                begin
                    // noise: a few entries out of order
                    n = $urandom_range(1, 4);
                    for (s = 0; s < n; s++)
                        send_request(OP_WRITE, IDX_W'($urandom), $urandom);
                end
                else
                begin
                    // ascending table; a zero step cap gives runs of duplicates
                    case ($urandom_range(4))
                        0:       step_cap = 0;
                        1:       step_cap = 3;
                        2:       step_cap = 1 << 12;
                        3:       step_cap = 1 << 20;
                        default: step_cap = 1 << 27;
                    endcase
                    span    = 64'd4294967296 - 15 * longint'(step_cap);
                    running = -64'd2147483648 + (longint'($urandom) % span);
                    if ($urandom_range(9) == 0)
                        running = -64'd2147483648;
                    for (s = 0; s < TABLE_DEPTH; s++)
                    begin
                        send_request(OP_WRITE, IDX_W'(s), running[31:0]);
                        running += longint'($urandom_range(step_cap));
                    end
                end

                n = $urandom_range(4, 20);
                for (s = 0; s < n; s++)
                begin
                    pick = $urandom_range(19);
                    if (pick < 10)
                        key = slot_words[IDX_W'($urandom_range(TABLE_DEPTH - 1))];
                    else if (pick < 14)
                        key = slot_words[IDX_W'($urandom_range(TABLE_DEPTH - 1))]
                              + ($urandom_range(1) ? 32'sd1 : -32'sd1);
                    else if (pick == 14)
                        key = WORD_MIN;
                    else if (pick == 15)
                        key = WORD_MAX;
                    else
                        key = $urandom;
                    if ($urandom_range(99) < 5)
                        send_request(OP_WRITE, IDX_W'($urandom), $urandom);
                    send_request(OP_SEARCH, IDX_W'($urandom), key);
                end
            end
        end
    endtask

    task automatic test_random_traffic();
        int unsigned third;
        begin
            third = (RANDOM_ITEMS - requests_sent) / 3;
            run_random_phase(37, 74, requests_sent + third);
            run_random_phase(74, 37, requests_sent + third);
            run_random_phase(0, 0, RANDOM_ITEMS);
        end
    endtask

    // Result side: ready toggles at the falling edge, results checked at the rising.
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);

    always @(posedge clk)
    begin : result_checker
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0d position=%0d probes=%0d",
                             rsp_ch.found, rsp_ch.position, rsp_ch.probes);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.found !== want.found || rsp_ch.position !== want.position
                    || rsp_ch.probes !== want.probes)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: expected found=%0d position=%0d probes=%0d,",
                                  " got found=%0d position=%0d probes=%0d"},
                                 results_checked, want.found, want.position, want.probes,
                                 rsp_ch.found, rsp_ch.position, rsp_ch.probes);
                end
                results_checked++;
            end
        end
    end

    // Watchdog: any request, result or register access resets the count.
    initial
    begin : stall_watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        // every input known from time zero
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_ch.valid = 1'b0;
        req_ch.op    = OP_WRITE;
        req_ch.index = '0;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        src_idle_pct = 37;
        rcv_idle_pct = 74;
        range_first  = FIRST_INDEX_RESET;
        range_last   = LAST_INDEX_RESET;
        requests_sent   = 0;
        writes_sent     = 0;
        searches_sent   = 0;
        hits_predicted  = 0;
        empty_ranges    = 0;
        range_settings  = 0;
        results_checked = 0;
        mismatches      = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_table_extremes();
        test_range_limits();
        test_unsorted_entry();
        test_random_traffic();
        drain_results();

        $display("Covered %0d requests: %0d table writes, %0d searches (%0d hits, %0d empty range).",
                 requests_sent, writes_sent, searches_sent, hits_predicted, empty_ranges);
        $display("%0d range settings, %0d results compared, %0d mismatches.",
                 range_settings, results_checked, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> sorted_table_binary_search.f
+incdir+rtl/core
rtl/core/sts_pkg.sv
rtl/core/sts_if.sv
rtl/core/sts_ram.sv
rtl/core/sts_cfg.sv
rtl/core/sts_engine.sv
rtl/core/sorted_table_binary_search.sv
rtl/core/sts_checker.sv
tb/tb_sorted_table_binary_search.sv
